FILE: rtl/otpsa_pkg.sv
// ----------------------------------------------------------------------------
// otpsa_pkg
// Shared constants, codes and types for the owner-tagged page slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package otpsa_pkg;

   // Field widths
   localparam int unsigned TAG_W   = 5;
   localparam int unsigned SLOT_W  = 5;
   localparam int unsigned COUNT_W = 5;

   // Default pool sizes
   localparam int unsigned TABLE_SLOTS_DEF = 24;
   localparam int unsigned DATA_SLOTS_DEF  = 16;

   // Tag used when the configured owner is zero
   localparam logic [TAG_W-1:0] NO_OWNER_TAG = 5'd31;
   localparam logic [TAG_W-1:0] OWNER_NONE   = 5'd0;

   // Command codes
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Pool codes
   localparam logic POOL_TABLE = 1'b0;
   localparam logic POOL_DATA  = 1'b1;

   // Status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_REL_RD,
      ST_REL_CMP,
      ST_FINISH
   } ctrl_state_type;

   // Per-pool commands from the sequencer
   typedef struct packed {
      logic rd_en;
      logic set;
      logic clear;
   } pool_cmd_type;

endpackage

`default_nettype wire

FILE: rtl/otpsa_if.sv
// ----------------------------------------------------------------------------
// otpsa_if
// Valid/ready channels for allocator commands and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface otpsa_req_if;
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic                           pool_select;
   logic [otpsa_pkg::TAG_W-1:0]    release_owner;

   modport source (output valid, command, pool_select, release_owner, input ready);
   modport sink   (input valid, command, pool_select, release_owner, output ready);
endinterface

interface otpsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           status;
   logic [otpsa_pkg::SLOT_W-1:0]   slot_index;
   logic [otpsa_pkg::COUNT_W-1:0]  table_used;
   logic [otpsa_pkg::COUNT_W-1:0]  data_used;

   modport source (output valid, status, slot_index, table_used, data_used, input ready);
   modport sink   (input valid, status, slot_index, table_used, data_used, output ready);
endinterface

`default_nettype wire

FILE: rtl/otpsa_pool.sv
// ----------------------------------------------------------------------------
// otpsa_pool
// One slot pool: owner tag memory, per-slot used bits and a used counter.
// ----------------------------------------------------------------------------
`default_nettype none

module otpsa_pool #(
   parameter int unsigned SLOTS = otpsa_pkg::DATA_SLOTS_DEF,
   localparam int unsigned ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   localparam int unsigned CNT_W  = $clog2(SLOTS + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire otpsa_pkg::pool_cmd_type        cmd,
   input  wire logic [ADDR_W-1:0]              addr,
   input  wire logic [otpsa_pkg::TAG_W-1:0]    wr_tag,
   output logic                                used_bit,
   output logic [otpsa_pkg::TAG_W-1:0]         rd_tag,
   output logic [otpsa_pkg::COUNT_W-1:0]       used_count
);
   import otpsa_pkg::*;

   logic [SLOTS-1:0]       used_ff, used_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [TAG_W-1:0]       tag_mem [SLOTS];
   logic [TAG_W-1:0]       rd_tag_ff;
   logic [CNT_W+COUNT_W-1:0] cnt_ext;
   logic                   addr_ok;

   // Used bits and count
   always_comb begin
      used_in = used_ff;
      cnt_in  = cnt_ff;
      if (cmd.set) begin
         used_in[addr] = 1'b1;
         cnt_in        = CNT_W'(cnt_ff + 1'b1);
      end else if (cmd.clear) begin
         used_in[addr] = 1'b0;
         cnt_in        = CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         used_ff <= used_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Tag memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.set) begin
         tag_mem[addr] <= wr_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_tag_ff <= tag_mem[addr];
      end
   end

   assign rd_tag = rd_tag_ff;

   // Out-of-range addresses read as used so a scan never grants them
   assign addr_ok  = ({1'b0, addr} < (ADDR_W+1)'(SLOTS));
   assign used_bit = addr_ok ? used_ff[addr] : 1'b1;

   // Saturate the reported count at the field maximum
   assign cnt_ext    = {{COUNT_W{1'b0}}, cnt_ff};
   assign used_count = (cnt_ext > (CNT_W+COUNT_W)'(31)) ? COUNT_W'(31) : cnt_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/otpsa_ctrl.sv
// ----------------------------------------------------------------------------
// otpsa_ctrl
// Slot sequencer: walks one slot per step for allocate and release scans,
// using a single shared owner compare.
// ----------------------------------------------------------------------------
`default_nettype none

module otpsa_ctrl #(
   parameter int unsigned TABLE_SLOTS = otpsa_pkg::TABLE_SLOTS_DEF,
   parameter int unsigned DATA_SLOTS  = otpsa_pkg::DATA_SLOTS_DEF,
   localparam int unsigned MAX_SLOTS = (TABLE_SLOTS > DATA_SLOTS) ? TABLE_SLOTS : DATA_SLOTS,
   localparam int unsigned IDX_W     = $clog2(MAX_SLOTS + 1)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // command side
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           command,
   input  wire logic                           pool_select,
   input  wire logic [otpsa_pkg::TAG_W-1:0]    release_owner,
   input  wire logic [otpsa_pkg::TAG_W-1:0]    alloc_owner,
   // pool side
   output logic [IDX_W-1:0]                    scan_idx,
   output logic [otpsa_pkg::TAG_W-1:0]         wr_tag,
   output otpsa_pkg::pool_cmd_type             tbl_cmd,
   output otpsa_pkg::pool_cmd_type             dat_cmd,
   input  wire logic                           tbl_used_bit,
   input  wire logic                           dat_used_bit,
   input  wire logic [otpsa_pkg::TAG_W-1:0]    tbl_rd_tag,
   input  wire logic [otpsa_pkg::TAG_W-1:0]    dat_rd_tag,
   // result side
   input  wire logic                           rsp_free,
   output logic                                done,
   output logic                                done_status,
   output logic [otpsa_pkg::SLOT_W-1:0]        done_slot
);
   import otpsa_pkg::*;

   ctrl_state_type          state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    pool_ff, pool_in;
   logic [TAG_W-1:0]        owner_ff, owner_in;
   logic [TAG_W-1:0]        tag_ff, tag_in;
   logic                    status_ff, status_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;

   logic [IDX_W-1:0]        limit;
   logic                    at_end;
   logic                    used_bit;
   logic [TAG_W-1:0]        rd_tag;
   logic                    owner_hit;
   logic [IDX_W+SLOT_W-1:0] idx_ext;
   pool_cmd_type            cmd;

   // Current pool view
   assign limit    = (pool_ff == POOL_DATA) ? IDX_W'(DATA_SLOTS) : IDX_W'(TABLE_SLOTS);
   assign at_end   = (idx_ff == limit);
   assign used_bit = (pool_ff == POOL_DATA) ? dat_used_bit : tbl_used_bit;
   assign rd_tag   = (pool_ff == POOL_DATA) ? dat_rd_tag : tbl_rd_tag;
   assign idx_ext  = {{SLOT_W{1'b0}}, idx_ff};

   // Shared compare: stored tag against the owner being released
   assign owner_hit = used_bit && (rd_tag == owner_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (command == CMD_ALLOC) begin
                  state_in = ST_ALLOC;
               end else if (release_owner == OWNER_NONE) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_REL_RD;
               end
            end
         end
         ST_ALLOC: begin
            if (at_end || !used_bit) begin
               state_in = ST_FINISH;
            end
         end
         ST_REL_RD: begin
            if (at_end && (pool_ff == POOL_DATA)) begin
               state_in = ST_FINISH;
            end else if (!at_end) begin
               state_in = ST_REL_CMP;
            end
         end
         ST_REL_CMP: begin
            state_in = ST_REL_RD;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates
   always_comb begin
      idx_in    = idx_ff;
      pool_in   = pool_ff;
      owner_in  = owner_ff;
      tag_in    = tag_ff;
      status_in = status_ff;
      slot_in   = slot_ff;
      cmd       = '0;
      req_ready = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               idx_in    = '0;
               pool_in   = (command == CMD_ALLOC) ? pool_select : POOL_TABLE;
               owner_in  = release_owner;
               tag_in    = (alloc_owner == OWNER_NONE) ? NO_OWNER_TAG : alloc_owner;
               status_in = STATUS_OK;
               slot_in   = '0;
            end
         end
         ST_ALLOC: begin
            if (at_end) begin
               status_in = STATUS_FULL;
               slot_in   = '0;
            end else if (!used_bit) begin
               cmd.set = 1'b1;
               slot_in = idx_ext[SLOT_W-1:0];
            end else begin
               idx_in = IDX_W'(idx_ff + 1'b1);
            end
         end
         ST_REL_RD: begin
            if (at_end) begin
               if (pool_ff == POOL_TABLE) begin
                  pool_in = POOL_DATA;
                  idx_in  = '0;
               end
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         ST_REL_CMP: begin
            cmd.clear = owner_hit;
            idx_in    = IDX_W'(idx_ff + 1'b1);
         end
         ST_FINISH: begin
            done = rsp_free;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   // Route the command to the active pool
   assign tbl_cmd = (pool_ff == POOL_TABLE) ? cmd : '0;
   assign dat_cmd = (pool_ff == POOL_DATA)  ? cmd : '0;

   assign scan_idx    = idx_ff;
   assign wr_tag      = tag_ff;
   assign done_status = status_ff;
   assign done_slot   = slot_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pool_ff   <= pool_in;
      owner_ff  <= owner_in;
      tag_ff    <= tag_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

endmodule

`default_nettype wire

FILE: rtl/owner_tagged_page_slot_allocator_unit.sv
// ----------------------------------------------------------------------------
// owner_tagged_page_slot_allocator_unit
// Owner-tagged first-free slot allocator over a table pool and a data pool.
// ----------------------------------------------------------------------------
//   Channel  Dir  Contents                                       Handshake
//   req      in   command, pool_select, release_owner            valid/ready
//   rsp      out  status, slot_index, table_used, data_used      valid/ready
//   csr      in   alloc_owner                                    write enable
//
// Allocate: scans the selected pool from slot zero up to the granted slot, or
// to the pool size when full; one used bit is checked per cycle.
// Release: each slot over both pools takes one tag memory read and one
// compare; owner zero skips the scan.
// Reset clears all used bits together; no clearing pass.
// One transaction is in work at a time; the result register lets the next
// command enter while the previous result waits on rsp.
// ----------------------------------------------------------------------------
`default_nettype none

module owner_tagged_page_slot_allocator_unit #(
   parameter int unsigned TABLE_SLOTS = otpsa_pkg::TABLE_SLOTS_DEF,
   parameter int unsigned DATA_SLOTS  = otpsa_pkg::DATA_SLOTS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   otpsa_req_if.sink                           req_chan,
   otpsa_rsp_if.source                         rsp_chan,
   input  wire logic                           csr_wr_en,
   input  wire logic [otpsa_pkg::TAG_W-1:0]    csr_wr_data
);
   import otpsa_pkg::*;

   localparam int unsigned MAX_SLOTS = (TABLE_SLOTS > DATA_SLOTS) ? TABLE_SLOTS : DATA_SLOTS;
   localparam int unsigned IDX_W     = $clog2(MAX_SLOTS + 1);
   localparam int unsigned TBL_AW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int unsigned DAT_AW    = (DATA_SLOTS > 1) ? $clog2(DATA_SLOTS) : 1;
   localparam logic [COUNT_W-1:0] TBL_MAX =
      COUNT_W'((TABLE_SLOTS > 31) ? 31 : TABLE_SLOTS);
   localparam logic [COUNT_W-1:0] DAT_MAX =
      COUNT_W'((DATA_SLOTS > 31) ? 31 : DATA_SLOTS);

   logic [TAG_W-1:0]    owner_ff;
   logic [IDX_W-1:0]    scan_idx;
   logic [TAG_W-1:0]    wr_tag;
   pool_cmd_type        tbl_cmd, dat_cmd;
   logic                tbl_used_bit, dat_used_bit;
   logic [TAG_W-1:0]    tbl_rd_tag, dat_rd_tag;
   logic [COUNT_W-1:0]  tbl_count, dat_count;
   logic                rsp_free, done, done_status;
   logic [SLOT_W-1:0]   done_slot;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [COUNT_W-1:0]  rsp_tbl_ff, rsp_dat_ff;

   // Owner register
   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff <= OWNER_NONE;
      end else if (csr_wr_en) begin
         owner_ff <= csr_wr_data;
      end
   end

   // Sequencer
   otpsa_ctrl #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .DATA_SLOTS  (DATA_SLOTS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .command       (req_chan.command),
      .pool_select   (req_chan.pool_select),
      .release_owner (req_chan.release_owner),
      .alloc_owner   (owner_ff),
      .scan_idx      (scan_idx),
      .wr_tag        (wr_tag),
      .tbl_cmd       (tbl_cmd),
      .dat_cmd       (dat_cmd),
      .tbl_used_bit  (tbl_used_bit),
      .dat_used_bit  (dat_used_bit),
      .tbl_rd_tag    (tbl_rd_tag),
      .dat_rd_tag    (dat_rd_tag),
      .rsp_free      (rsp_free),
      .done          (done),
      .done_status   (done_status),
      .done_slot     (done_slot)
   );

   // Table pool
   otpsa_pool #(
      .SLOTS (TABLE_SLOTS)
   ) u_table_pool (
      .clock      (clock),
      .reset      (reset),
      .cmd        (tbl_cmd),
      .addr       (scan_idx[TBL_AW-1:0]),
      .wr_tag     (wr_tag),
      .used_bit   (tbl_used_bit),
      .rd_tag     (tbl_rd_tag),
      .used_count (tbl_count)
   );

   // Data pool
   otpsa_pool #(
      .SLOTS (DATA_SLOTS)
   ) u_data_pool (
      .clock      (clock),
      .reset      (reset),
      .cmd        (dat_cmd),
      .addr       (scan_idx[DAT_AW-1:0]),
      .wr_tag     (wr_tag),
      .used_bit   (dat_used_bit),
      .rd_tag     (dat_rd_tag),
      .used_count (dat_count)
   );

   // Result register
   assign rsp_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = done ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_status_ff <= done_status;
         rsp_slot_ff   <= done_slot;
         rsp_tbl_ff    <= tbl_count;
         rsp_dat_ff    <= dat_count;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.slot_index = rsp_slot_ff;
   assign rsp_chan.table_used = rsp_tbl_ff;
   assign rsp_chan.data_used  = rsp_dat_ff;

`ifndef SYNTHESIS
   // A command is worked on alone: no second transaction right after one
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("command accepted while another is in work");

   // A finished command always lands in the result register
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_chan.valid)
      else $error("finished command did not produce a result");

   // A full pool grants no slot
   a_full_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == STATUS_FULL) |-> (rsp_chan.slot_index == '0))
      else $error("full status with a nonzero slot index");

   // Used counts never exceed the pool sizes
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.table_used <= TBL_MAX) && (rsp_chan.data_used <= DAT_MAX))
      else $error("used count beyond pool size");
`endif

endmodule

`default_nettype wire
